/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the sorted priority queue core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SPQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
	else $error("spq assertion failed");
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("spq assertion failed");
`else
`define SPQ_ASSERT(lbl, clk, rstn, prop)
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/spq_pkg.sv */
// Types and codes shared by the sorted priority queue cells and top level
package spq_pkg;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} spq_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} spq_status_t;

	// Broadcast from the top level to every cell
	typedef struct packed {
		logic               push;
		logic               pop;
		logic signed [31:0] value;
		logic signed [15:0] rank;
	} spq_cmd_t;

	// What a cell shows its neighbors
	typedef struct packed {
		logic signed [31:0] data;
		logic signed [15:0] rank;
		logic               after;
	} spq_link_t;

endpackage

/* rtl/core/spq_cell.sv */
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors
module spq_cell (
	input  logic             clk,
	input  spq_pkg::spq_cmd_t  cmd,
	input  logic             occupied,
	input  spq_pkg::spq_link_t left,
	input  spq_pkg::spq_link_t right,
	output spq_pkg::spq_link_t link
);
	import spq_pkg::*;

	logic signed [31:0] data_q;
	logic signed [15:0] rank_q;
	logic               after;

	// new entry goes behind this one
	assign after = occupied && (rank_q <= cmd.rank);

	assign link.data  = data_q;
	assign link.rank  = rank_q;
	assign link.after = after;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (!after) begin
				if (left.after) begin
					data_q <= cmd.value;
					rank_q <= cmd.rank;
				end else begin
					data_q <= left.data;
					rank_q <= left.rank;
				end
			end
		end else if (cmd.pop) begin
			data_q <= right.data;
			rank_q <= right.rank;
		end
	end

endmodule

/* rtl/core/sorted_priority_queue_core.sv */
// Sorted priority queue: a chain of shifting cells, min rank first, stable
// The result is registered, in the cycle after the request is accepted.
// Throughput: one request per cycle while each result is taken; all cells compare the new rank in parallel.
// The result register frees as it is taken, so requests flow while results drain.
// Reset clears the entry count and the result valid flag; cell contents and the
// result payload are left as they are, and no clearing pass runs.
`include "assert_macros.svh"
module sorted_priority_queue_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic signed [31:0] item_value,
	input  logic signed [15:0] item_rank,
	output logic        res_valid,
	input  logic        res_ready,
	output logic signed [31:0] out_value,
	output logic        out_valid,
	output logic [1:0]  status,
	output logic [4:0]  fill_count
);
	import spq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]  count_q;
	logic           res_valid_q;
	logic signed [31:0] out_value_q;
	logic           out_valid_q;
	spq_status_t    status_q;
	logic [4:0]     fill_q;

	logic           accept;
	logic           full;
	logic           empty;
	logic [CW-1:0]  count_next;
	spq_cmd_t       cmd;
	spq_link_t      link [QUEUE_DEPTH];
	spq_link_t      head_link;

	assign in_ready = !res_valid_q || res_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);

	assign cmd.push  = accept && (operation == OP_ENQ) && !full;
	assign cmd.pop   = accept && (operation == OP_DEQ) && !empty;
	assign cmd.value = item_value;
	assign cmd.rank  = item_rank;

	assign head_link.data  = '0;
	assign head_link.rank  = '0;
	assign head_link.after = 1'b1;

	always_comb begin
		count_next = count_q;
		if (cmd.push) begin
			count_next = count_q + 1'b1;
		end else if (cmd.pop) begin
			count_next = count_q - 1'b1;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		spq_link_t left_link;
		spq_link_t right_link;
		logic      occupied;

		assign occupied = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_link = head_link;
		end else begin : g_body
			assign left_link = link[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_link = link[i];
		end else begin : g_inner
			assign right_link = link[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occupied (occupied),
			.left     (left_link),
			.right    (right_link),
			.link     (link[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fill_q      <= 5'(count_next);
			out_value_q <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			unique case (operation)
				OP_ENQ: begin
					if (full) begin
						status_q <= ST_OVERFLOW;
					end
				end
				OP_DEQ: begin
					if (empty) begin
						status_q <= ST_UNDERFLOW;
					end else begin
						out_value_q <= link[0].data;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign out_value  = out_value_q;
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign fill_count = fill_q;

	`SPQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(QUEUE_DEPTH))
	`SPQ_ASSERT_NEXT(a_push_count, clk, arst_n, cmd.push, count_q == $past(count_q) + 1'b1)
	`SPQ_ASSERT_NEXT(a_underflow, clk, arst_n, accept && (operation == OP_DEQ) && empty, status_q == ST_UNDERFLOW && !out_valid_q)
	`SPQ_ASSERT(a_valid_ok, clk, arst_n, !(res_valid_q && out_valid_q) || status_q == ST_OK)

endmodule
